// ===== rtl/bpfa_pkg.sv =====
// Shared constants, operation codes and types of the bitmap page-frame allocator.
package bpfa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 131072;
  localparam int unsigned RESERVED_DEF  = 256;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned ATTR_W  = 12;
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 12'd7;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Port strobes from the controller to the bitmap store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bmp_ctl_t;

endpackage

// ===== rtl/bpfa_if.sv =====
// Request and response channel interfaces of the bitmap page-frame allocator.
interface bpfa_req_if;
  import bpfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  frame_sel;

  modport source (output valid, output op, output frame_sel, input ready);
  modport sink (input valid, input op, input frame_sel, output ready);
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [IDX_W-1:0]   frame;
  logic [ENTRY_W-1:0] entry_word;
  logic               is_used;

  modport source (output valid, output status, output frame, output entry_word,
                  output is_used, input ready);
  modport sink (input valid, input status, input frame, input entry_word,
                input is_used, output ready);
endinterface

// ===== rtl/bpfa_bitmap_store.sv =====
// Usage bitmap memory with one read and one write port and its clearing pass after reset.
module bpfa_bitmap_store #(
  parameter int unsigned NUM_PAGES      = bpfa_pkg::NUM_PAGES_DEF,
  parameter int unsigned RESERVED_PAGES = bpfa_pkg::RESERVED_DEF,
  localparam int unsigned WORDS = (NUM_PAGES + 31) / 32,
  localparam int unsigned AW    = $clog2(WORDS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpfa_pkg::bmp_ctl_t            ctl_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [bpfa_pkg::WORD_W-1:0]   wr_data_i,
  output logic [bpfa_pkg::WORD_W-1:0]   rd_data_o,
  output logic                          ready_o
);
  import bpfa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_q;
  logic              init_busy_q;
  logic [AW-1:0]     init_cnt_q;

  // Reset contents of one word: frames below the reserved count are used.
  function automatic logic [WORD_W-1:0] init_word(input logic [AW-1:0] w);
    int unsigned base;
    base = 32'(w) << BIT_W;
    if (RESERVED_PAGES >= base + WORD_W) begin
      return '1;
    end else if (RESERVED_PAGES <= base) begin
      return '0;
    end else begin
      return ~({WORD_W{1'b1}} << (RESERVED_PAGES - base));
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_cnt_q  <= '0;
    end else if (init_busy_q) begin
      init_cnt_q <= init_cnt_q + AW'(1);
      if (init_cnt_q == AW'(WORDS - 1)) begin
        init_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_busy_q) begin
      mem[init_cnt_q] <= init_word(init_cnt_q);
    end else if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~init_busy_q;

endmodule

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Top level of the next-fit bitmap page-frame allocator.
//
// The allocator keeps one usage bit per page frame in a synchronous memory of
// 32-bit words and a next-fit cursor. After reset a clearing pass writes the
// reset contents into the memory, one word per cycle, and requests are held
// off until it has covered all (NUM_PAGES + 31) / 32 words (4096 words with
// the default parameters); configuration writes are taken at any time. An
// allocate transaction reads the word under the cursor and then one word per
// cycle, wrapping, until a free frame turns up; the first word is examined
// twice, above the cursor at the start and below it at the end, so a full lap is
// (NUM_PAGES + 31) / 32 + 1 words. The word reads are what bound an allocate; it
// ends when a frame is found or the lap is done, once the output register is
// free. Free and query transactions do the word read and then, once the output
// register is free, the bit update and write-back for a free or the bit lookup
// for a query. Only one transaction is in flight at a time; the response sits in
// an output register, so a new request is accepted while the previous response
// waits to be taken. The entry word returned by an allocate is the frame number
// shifted left by twelve with the page_attr register in the low bits; page_attr
// resets to 7. A frame number at or above NUM_PAGES on free or query changes
// nothing and echoes the index.
module bitmap_page_frame_allocator_top #(
  parameter int unsigned NUM_PAGES      = bpfa_pkg::NUM_PAGES_DEF,
  parameter int unsigned RESERVED_PAGES = bpfa_pkg::RESERVED_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpfa_pkg::ATTR_W-1:0] cfg_data_i,
  bpfa_req_if.sink                    req_i,
  bpfa_rsp_if.source                  rsp_o
);
  import bpfa_pkg::*;

  localparam int unsigned WORDS     = (NUM_PAGES + 31) / 32;
  localparam int unsigned AW        = $clog2(WORDS);
  localparam int unsigned FW        = $clog2(NUM_PAGES);
  localparam int unsigned CW        = $clog2(WORDS + 1);
  localparam int unsigned LAST_BITS = NUM_PAGES - (WORDS - 1) * 32;
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << LAST_BITS);
  localparam logic [FW-1:0] CURSOR_RST =
    (RESERVED_PAGES < NUM_PAGES) ? FW'(RESERVED_PAGES) : '0;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OP   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [FW-1:0]      cursor_q, cursor_d;
  logic [AW-1:0]      chk_q, chk_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [ATTR_W-1:0]  attr_q;
  logic [OP_W-1:0]    op_q;
  logic [IDX_W-1:0]   idx_q;

  logic               out_valid_q;
  logic               out_status_q;
  logic [IDX_W-1:0]   out_frame_q;
  logic [ENTRY_W-1:0] out_entry_q;
  logic               out_used_q;

  bmp_ctl_t           ctl;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data, rd_data;
  logic               store_ready;

  logic               in_ready, out_free, out_load, oob;
  logic               res_status, res_used;
  logic [IDX_W-1:0]   res_frame;
  logic [ENTRY_W-1:0] res_entry;

  logic [AW-1:0]      cur_word, idx_word_in, idx_word_q, chk_nxt;
  logic [WORD_W-1:0]  cand, first_mask, last_mask;
  logic               found;
  logic [BIT_W-1:0]   bit_pos;
  logic [FW-1:0]      frame_found, cursor_nxt;

  bpfa_bitmap_store #(
    .NUM_PAGES      (NUM_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .ready_o   (store_ready)
  );

  // Word addresses of the cursor and of the requested frame.
  assign cur_word    = AW'(cursor_q >> BIT_W);
  assign idx_word_in = AW'(FW'(req_i.frame_sel) >> BIT_W);
  assign idx_word_q  = AW'(FW'(idx_q) >> BIT_W);
  assign oob         = 32'(idx_q) >= 32'(NUM_PAGES);
  assign chk_nxt     = (chk_q == AW'(WORDS - 1)) ? '0 : chk_q + AW'(1);

  // The first look at the cursor word skips frames below the cursor; the
  // last look at the same word covers exactly those frames. Frames past the
  // end of the frame range in the last word do not exist and are never free.
  assign first_mask = (cnt_q == '0) ? ({WORD_W{1'b1}} << cursor_q[BIT_W-1:0])
                                    : {WORD_W{1'b1}};
  assign last_mask  = (cnt_q == CW'(WORDS)) ? ~({WORD_W{1'b1}} << cursor_q[BIT_W-1:0])
                                            : {WORD_W{1'b1}};
  assign cand = ~rd_data & first_mask & last_mask
              & ((chk_q == AW'(WORDS - 1)) ? TAIL_MASK : {WORD_W{1'b1}});
  assign found = |cand;

  always_comb begin
    bit_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        bit_pos = BIT_W'(b);
      end
    end
  end

  assign frame_found = FW'({chk_q, bit_pos});
  assign cursor_nxt  = (frame_found == FW'(NUM_PAGES - 1)) ? '0 : frame_found + FW'(1);

  assign in_ready = store_ready && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    chk_d      = chk_q;
    cnt_d      = cnt_q;
    ctl        = '0;
    rd_addr    = chk_q;
    wr_addr    = chk_q;
    wr_data    = rd_data;
    out_load   = 1'b0;
    res_status = 1'b0;
    res_frame  = '0;
    res_entry  = '0;
    res_used   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid && in_ready) begin
          ctl.rd_en = 1'b1;
          if (req_i.op == OP_ALLOC) begin
            rd_addr = cur_word;
            chk_d   = cur_word;
            cnt_d   = '0;
            state_d = ST_SCAN;
          end else begin
            rd_addr = idx_word_in;
            state_d = ST_OP;
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          if (out_free) begin
            ctl.wr_en = 1'b1;
            wr_addr   = chk_q;
            wr_data   = rd_data | (WORD_W'(1) << bit_pos);
            out_load  = 1'b1;
            res_frame = IDX_W'(frame_found);
            res_entry = ENTRY_W'({frame_found, attr_q});
            res_used  = 1'b1;
            cursor_d  = cursor_nxt;
            state_d   = ST_IDLE;
          end
        end else if (cnt_q == CW'(WORDS)) begin
          if (out_free) begin
            out_load   = 1'b1;
            res_status = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          ctl.rd_en = 1'b1;
          rd_addr   = chk_nxt;
          chk_d     = chk_nxt;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      ST_OP: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_frame = idx_q;
          state_d   = ST_IDLE;
          if (!oob) begin
            if (op_q == OP_FREE) begin
              ctl.wr_en = 1'b1;
              wr_addr   = idx_word_q;
              wr_data   = rd_data & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
            end else begin
              res_used = rd_data[idx_q[BIT_W-1:0]];
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= CURSOR_RST;
      chk_q       <= '0;
      cnt_q       <= '0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      chk_q    <= chk_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      op_q  <= req_i.op;
      idx_q <= req_i.frame_sel;
    end
    if (out_load) begin
      out_status_q <= res_status;
      out_frame_q  <= res_frame;
      out_entry_q  <= res_entry;
      out_used_q   <= res_used;
    end
  end

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.frame      = out_frame_q;
  assign rsp_o.entry_word = out_entry_q;
  assign rsp_o.is_used    = out_used_q;

  // Reads and write-backs never share a cycle, so a read never sees stale data.
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.rd_en && ctl.wr_en))
    else $error("bitmap read and write issued in the same cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) < 32'(NUM_PAGES))
    else $error("next-fit cursor outside the frame range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CW'(WORDS)))
    else $error("allocate scan ran past one full lap");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE) && !req_i.ready)
    else $error("a request was accepted without starting its work");

endmodule
